FILE: src/tctsr_pkg.sv
// ---------------------------------------------------------------------------
// tctsr_pkg: shared types and constants for the TCP connection table
// Field widths, stream packing positions, controller states and the
// structs that carry the search token and the write command along the cells.
// ---------------------------------------------------------------------------
package tctsr_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;

    localparam int IP_W         = 32;
    localparam int PORT_W       = 16;
    localparam int SEQ_W        = 32;
    localparam int HDR_W        = 4;
    localparam int CONN_INDEX_W = 6;

    localparam logic [HDR_W-1:0] HEADER_WORDS = 4'd5;

    // slave stream: tdata = peer_ip, peer_port, local_port, peer_seq, random_seq
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 4;
    localparam int SU_SYN    = 0;
    localparam int SU_ACK    = 1;
    localparam int SU_PSH    = 2;
    localparam int SU_FIN    = 3;

    // master stream: tdata = conn_index, reply ports, seq, ack, header words
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 3;
    localparam int MU_CONN    = 0;
    localparam int MU_CREATED = 1;
    localparam int MU_REPLY   = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    // search token flags handed from cell to cell
    typedef struct packed {
        logic vld;
        logic hit;
        logic free;
    } t_tok;

    // write command broadcast to all cells
    typedef struct packed {
        logic en;
        logic create;
        logic syn;
    } t_wr;

endpackage

FILE: src/tctsr_cell.sv
// ---------------------------------------------------------------------------
// tctsr_cell: one connection table entry
// Holds one peer entry, compares it with the broadcast query when the search
// token passes, and hands the updated token to the next cell in the following cycle.
// ---------------------------------------------------------------------------
module tctsr_cell
    import tctsr_pkg::*;
#(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tok              i_tok,
    input  logic [IDX_W-1:0]  i_hit_idx,
    input  logic [IDX_W-1:0]  i_free_idx,
    output t_tok              o_tok,
    output logic [IDX_W-1:0]  o_hit_idx,
    output logic [IDX_W-1:0]  o_free_idx,
    input  logic [IP_W-1:0]   i_q_ip,
    input  logic [PORT_W-1:0] i_q_port,
    input  logic [SEQ_W-1:0]  i_q_seq,
    input  logic [SEQ_W-1:0]  i_q_rnd,
    input  logic [SEQ_W-1:0]  i_q_ack,
    input  t_wr               i_wr,
    input  logic [IDX_W-1:0]  i_wr_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic              r_used;
    logic [IP_W-1:0]   r_ip;
    logic [PORT_W-1:0] r_port;
    logic [SEQ_W-1:0]  r_local_seq;
    logic [SEQ_W-1:0]  r_ack_num;
    t_tok              r_tok;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [IDX_W-1:0]  r_free_idx;

    logic match;
    logic sel;

    assign match = r_used && (r_ip == i_q_ip) && (r_port == i_q_port);
    assign sel   = i_wr.en && (i_wr_idx == MY_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_tok.vld  <= i_tok.vld;
            r_tok.hit  <= i_tok.hit | match;
            r_tok.free <= i_tok.free | !r_used;
            if (sel && i_wr.create) begin
                r_used <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // keep the earliest hit and the lowest free entry
        r_hit_idx  <= i_tok.hit  ? i_hit_idx  : MY_IDX;
        r_free_idx <= i_tok.free ? i_free_idx : MY_IDX;
        if (sel) begin
            if (i_wr.create) begin
                r_ip        <= i_q_ip;
                r_port      <= i_q_port;
                r_local_seq <= i_q_seq;
            end
            if (i_wr.syn) begin
                r_local_seq <= i_q_rnd;
                r_ack_num   <= i_q_ack;
            end
        end
    end

    assign o_tok      = r_tok;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule

FILE: src/tcp_connection_table_syn_reply.sv
// ---------------------------------------------------------------------------
// tcp_connection_table_syn_reply: passive-open connection table
// Looks up the peer of each TCP header, claims a free entry on a miss and
// answers a pure SYN with a SYN-ACK reply.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one decoded header per transaction. tdata holds
//   peer_ip, peer_port, local_port, peer_seq and random_seq; tuser holds the
//   SYN, ACK, PSH and FIN flags. Master stream returns exactly one result
//   transaction per header: conn_index and the reply fields in tdata,
//   conn_valid, created and reply_valid in tuser.
//   The table is a chain of TABLE_ENTRIES cells, one entry per cell. A
//   search token enters cell 0 the cycle after the header is taken and moves
//   one cell per cycle, collecting the first matching entry and the lowest
//   free entry. The result is latched as the token leaves the last cell and
//   is committed (table write plus output register load) once the output
//   register is free. One header is searched at a time; the next is taken
//   only after the previous result has been committed. Reset clears every
//   entry's used bit at once, so the table is empty and ready as soon as
//   reset is released; no clearing pass is needed.
//   A stalled master side holds the result in the output register; the next
//   header is still taken and searched, and its commit waits until the
//   output register is free.
// ---------------------------------------------------------------------------
module tcp_connection_table_syn_reply
    import tctsr_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [31:0] peer_ip, [47:32] peer_port, [63:48] local_port,
    // [95:64] peer_seq, [127:96] random_seq
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // [0] flag_syn, [1] flag_ack, [2] flag_psh, [3] flag_fin
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [5:0] conn_index, [21:6] reply_src_port, [37:22] reply_dst_port,
    // [69:38] reply_seq, [101:70] reply_ack_num, [105:102] reply_header_words,
    // [111:106] zero
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // [0] conn_valid, [1] created, [2] reply_valid
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // controller state
    t_state r_state, n_state;

    // query held for the whole search
    logic [IP_W-1:0]   r_q_ip;
    logic [PORT_W-1:0] r_q_port;
    logic [PORT_W-1:0] r_q_lport;
    logic [SEQ_W-1:0]  r_q_seq;
    logic [SEQ_W-1:0]  r_q_rnd;
    logic              r_q_pure_syn;
    logic              r_launch;
    logic [SEQ_W-1:0]  q_ack;

    // search result latched from the end of the chain
    logic             r_hit;
    logic             r_free;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] r_free_idx;

    // output register
    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TUSER_W-1:0] r_m_tuser;
    logic [M_TDATA_W-1:0] n_m_tdata;
    logic [M_TUSER_W-1:0] n_m_tuser;

    // cell chain
    t_tok             tok      [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] hit_idx  [0:TABLE_ENTRIES];
    logic [IDX_W-1:0] free_idx [0:TABLE_ENTRIES];

    logic             s_accept;
    logic             out_free;
    logic             commit;
    logic             slot_ok;
    logic [IDX_W-1:0] slot;
    logic             reply;
    t_wr              wr;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_tvalid || i_m_tready;
    assign commit   = (r_state == ST_DONE) && out_free;
    assign slot_ok  = r_hit || r_free;
    assign slot     = r_hit ? r_hit_idx : r_free_idx;
    assign reply    = slot_ok && r_q_pure_syn;
    assign q_ack    = r_q_seq + SEQ_W'(1);

    assign wr.en     = commit && slot_ok;
    assign wr.create = !r_hit;
    assign wr.syn    = r_q_pure_syn;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state: take a header, walk the chain, commit when output is free
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (tok[TABLE_ENTRIES].vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);

    // launch pulse and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch   <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_launch <= s_accept;
            if (commit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // capture the query on acceptance
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_q_ip       <= i_s_tdata[31:0];
            r_q_port     <= i_s_tdata[47:32];
            r_q_lport    <= i_s_tdata[63:48];
            r_q_seq      <= i_s_tdata[95:64];
            r_q_rnd      <= i_s_tdata[127:96];
            r_q_pure_syn <= i_s_tuser[SU_SYN] && !i_s_tuser[SU_ACK]
                            && !i_s_tuser[SU_PSH] && !i_s_tuser[SU_FIN];
        end
    end

    // hold the token result once it leaves the last cell
    always_ff @(posedge i_clk) begin
        if (tok[TABLE_ENTRIES].vld) begin
            r_hit      <= tok[TABLE_ENTRIES].hit;
            r_free     <= tok[TABLE_ENTRIES].free;
            r_hit_idx  <= hit_idx[TABLE_ENTRIES];
            r_free_idx <= free_idx[TABLE_ENTRIES];
        end
    end

    // build the result; zero every field that does not apply
    always_comb begin
        n_m_tdata = '0;
        n_m_tuser = '0;
        n_m_tuser[MU_CONN]    = slot_ok;
        n_m_tuser[MU_CREATED] = slot_ok && !r_hit;
        n_m_tuser[MU_REPLY]   = reply;
        if (slot_ok) begin
            n_m_tdata[5:0] = CONN_INDEX_W'(slot);
        end
        if (reply) begin
            n_m_tdata[21:6]    = r_q_lport;
            n_m_tdata[37:22]   = r_q_port;
            n_m_tdata[69:38]   = r_q_rnd;
            n_m_tdata[101:70]  = q_ack;
            n_m_tdata[105:102] = HEADER_WORDS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_m_tdata <= n_m_tdata;
            r_m_tuser <= n_m_tuser;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // token enters cell 0 with nothing found yet
    assign tok[0].vld  = r_launch;
    assign tok[0].hit  = 1'b0;
    assign tok[0].free = 1'b0;
    assign hit_idx[0]  = '0;
    assign free_idx[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        tctsr_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (tok[g]),
            .i_hit_idx  (hit_idx[g]),
            .i_free_idx (free_idx[g]),
            .o_tok      (tok[g+1]),
            .o_hit_idx  (hit_idx[g+1]),
            .o_free_idx (free_idx[g+1]),
            .i_q_ip     (r_q_ip),
            .i_q_port   (r_q_port),
            .i_q_seq    (r_q_seq),
            .i_q_rnd    (r_q_rnd),
            .i_q_ack    (q_ack),
            .i_wr       (wr),
            .i_wr_idx   (slot)
        );
    end

endmodule

FILE: src/tctsr_chk.sv
// ---------------------------------------------------------------------------
// tctsr_chk: port-level checks for the connection table
// Watches the stream ports of the top level and flags inconsistent results.
// ---------------------------------------------------------------------------
module tctsr_chk
    import tctsr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [M_TUSER_W-1:0] o_m_tuser
);

    // one header at a time: no back-to-back acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("header accepted while a search is running");

    // a reply or a new entry needs a connection
    a_reply_needs_conn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[MU_REPLY] || o_m_tuser[MU_CREATED]))
        |-> o_m_tuser[MU_CONN])
        else $error("reply or created without a connection");

    // no connection: every field zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[MU_CONN]) |-> (o_m_tdata == '0))
        else $error("full-table result carries data");

    // a reply always carries a five-word header
    a_reply_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[MU_REPLY]) |-> (o_m_tdata[105:102] == HEADER_WORDS))
        else $error("reply header length wrong");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind tcp_connection_table_syn_reply tctsr_chk u_tctsr_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the TCP passive-open connection table
// Streams decoded TCP headers into the table and predicts each result
// transaction from a local copy of the table: peer lookup, claim of the
// lowest free entry on a miss, SYN-ACK reply on a pure SYN, and an all-zero
// result once the table is full. Both stream sides idle at random; a long
// receiver hold-off and a sender drain pause press on the handshakes.
// ---------------------------------------------------------------------------
module tb_top;
    import tctsr_pkg::*;

    localparam int TBL          = DEF_TABLE_ENTRIES;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int MAX_REPORTS  = 200;

    localparam logic [S_TUSER_W-1:0] FL_NONE = '0;
    localparam logic [S_TUSER_W-1:0] FL_SYN  = S_TUSER_W'(1 << SU_SYN);
    localparam logic [S_TUSER_W-1:0] FL_ACK  = S_TUSER_W'(1 << SU_ACK);
    localparam logic [S_TUSER_W-1:0] FL_PSH  = S_TUSER_W'(1 << SU_PSH);
    localparam logic [S_TUSER_W-1:0] FL_FIN  = S_TUSER_W'(1 << SU_FIN);

    // one decoded header as offered on the slave stream
    typedef struct {
        logic [IP_W-1:0]      peer_ip;
        logic [PORT_W-1:0]    peer_port;
        logic [PORT_W-1:0]    local_port;
        logic [SEQ_W-1:0]     peer_seq;
        logic [S_TUSER_W-1:0] flags;
        logic [SEQ_W-1:0]     random_seq;
        bit                   drain_first;   // hold until all results are back
    } t_segment;

    // one result as carried by the master stream
    typedef struct packed {
        logic                    conn_valid;
        logic                    created;
        logic                    reply_valid;
        logic [CONN_INDEX_W-1:0] conn_index;
        logic [PORT_W-1:0]       src_port;
        logic [PORT_W-1:0]       dst_port;
        logic [SEQ_W-1:0]        seq;
        logic [SEQ_W-1:0]        ack_num;
        logic [HDR_W-1:0]        hdr_words;
    } t_conn_result;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic [S_TUSER_W-1:0] i_s_tuser  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;

    tcp_connection_table_syn_reply #(
        .TABLE_ENTRIES(TBL)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // -----------------------------------------------------------------------
    // Local copy of the connection table
    // -----------------------------------------------------------------------
    bit              tbl_used      [TBL];
    logic [IP_W-1:0] tbl_peer_ip   [TBL];
    logic [PORT_W-1:0] tbl_peer_port [TBL];
    logic [SEQ_W-1:0] tbl_local_seq [TBL];
    logic [SEQ_W-1:0] tbl_ack_num   [TBL];

    t_segment     segment_q[$];          // headers still to be offered
    t_conn_result awaited_results[$];    // predictions for accepted headers
    t_segment     cur_seg;               // header currently on the slave bus

    int  queued        = 0;
    int  sent_count    = 0;
    int  accepted      = 0;
    int  results_seen  = 0;
    int  replies_seen  = 0;
    int  created_seen  = 0;
    int  full_misses   = 0;
    int  err_count     = 0;
    int  cycles        = 0;
    bit  seg_taken     = 1'b0;
    bit  drain_next    = 1'b0;

    logic [IP_W-1:0]   ip_set  [8];
    logic [PORT_W-1:0] port_set[8];

    // Look the peer up, claim the lowest free entry on a miss and work out
    // the result transaction this header must produce.
    function automatic t_conn_result track_segment(t_segment s);
        t_conn_result r;
        int           slot;
        r    = '0;
        slot = -1;
        for (int i = 0; i < TBL; i++) begin
            if (slot < 0 && tbl_used[i] && tbl_peer_ip[i] == s.peer_ip &&
                tbl_peer_port[i] == s.peer_port) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            for (int i = 0; i < TBL; i++) begin
                if (slot < 0 && !tbl_used[i]) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                tbl_used[slot]      = 1'b1;
                tbl_peer_ip[slot]   = s.peer_ip;
                tbl_peer_port[slot] = s.peer_port;
                tbl_local_seq[slot] = s.peer_seq;
                r.created           = 1'b1;
            end
        end
        // full table: no connection, no reply, all fields zero
        if (slot < 0) begin
            full_misses++;
            return r;
        end
        r.conn_valid = 1'b1;
        r.conn_index = CONN_INDEX_W'(slot);
        if (s.flags == FL_SYN) begin
            tbl_local_seq[slot] = s.random_seq;
            tbl_ack_num[slot]   = s.peer_seq + 32'd1;
            r.reply_valid       = 1'b1;
            r.src_port          = s.local_port;
            r.dst_port          = s.peer_port;
            r.seq               = s.random_seq;
            r.ack_num           = s.peer_seq + 32'd1;
            r.hdr_words         = HEADER_WORDS;
        end
        return r;
    endfunction

    task automatic queue_segment(input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] pport,
                                 input logic [PORT_W-1:0] lport, input logic [SEQ_W-1:0] pseq,
                                 input logic [S_TUSER_W-1:0] flags,
                                 input logic [SEQ_W-1:0] rnd);
        t_segment s;
        s.peer_ip     = ip;
        s.peer_port   = pport;
        s.local_port  = lport;
        s.peer_seq    = pseq;
        s.flags       = flags;
        s.random_seq  = rnd;
        s.drain_first = drain_next;
        drain_next    = 1'b0;
        segment_q.push_back(s);
        queued++;
    endtask

    // Sequence numbers lean on the wrap points now and then.
    function automatic logic [SEQ_W-1:0] pick_seq();
        int unsigned sel;
        sel = $urandom_range(15);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return $urandom();
    endfunction

    // Mostly peers from a pool that shares addresses and ports, so that
    // near misses on one half of the key are common; sometimes a fresh peer.
    task automatic pick_peer(output logic [IP_W-1:0] ip, output logic [PORT_W-1:0] port);
        int unsigned k;
        if ($urandom_range(99) < 85) begin
            k    = $urandom_range(55);
            ip   = ip_set[k / 8];
            port = port_set[k % 8];
        end else begin
            ip   = $urandom();
            port = PORT_W'($urandom());
        end
    endtask

    task automatic check_field(input string fname, input logic [SEQ_W-1:0] got,
                               input logic [SEQ_W-1:0] want);
        if (got !== want) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
                $display("%0t: result %0d %s mismatch: expected %h, actual %h",
                         $time, results_seen, fname, want, got);
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Run limit: end the run if the handshakes never finish
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Predict on each
    // accepted header, check each accepted result against the oldest
    // prediction.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_conn_result want;
        t_conn_result got;
        seg_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (seg_taken) begin
            awaited_results.push_back(track_segment(cur_seg));
            accepted++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.conn_valid  = o_m_tuser[MU_CONN];
            got.created     = o_m_tuser[MU_CREATED];
            got.reply_valid = o_m_tuser[MU_REPLY];
            got.conn_index  = o_m_tdata[5:0];
            got.src_port    = o_m_tdata[21:6];
            got.dst_port    = o_m_tdata[37:22];
            got.seq         = o_m_tdata[69:38];
            got.ack_num     = o_m_tdata[101:70];
            got.hdr_words   = o_m_tdata[105:102];
            if (awaited_results.size() == 0) begin
                err_count++;
                $display("%0t: result transaction with no header pending: expected none, actual %h / %h",
                         $time, o_m_tuser, o_m_tdata);
            end else begin
                want = awaited_results.pop_front();
                check_field("conn_valid", 32'(got.conn_valid), 32'(want.conn_valid));
                check_field("created", 32'(got.created), 32'(want.created));
                check_field("reply_valid", 32'(got.reply_valid), 32'(want.reply_valid));
                check_field("conn_index", 32'(got.conn_index), 32'(want.conn_index));
                check_field("reply_src_port", 32'(got.src_port), 32'(want.src_port));
                check_field("reply_dst_port", 32'(got.dst_port), 32'(want.dst_port));
                check_field("reply_seq", got.seq, want.seq);
                check_field("reply_ack_num", got.ack_num, want.ack_num);
                check_field("reply_header_words", 32'(got.hdr_words), 32'(want.hdr_words));
                check_field("tdata pad", 32'(o_m_tdata[111:106]), 32'd0);
                if (want.reply_valid) replies_seen++;
                if (want.created) created_seen++;
            end
            results_seen++;
        end
    end

    // -----------------------------------------------------------------------
    // Driver: change the slave side at the falling edge. Hold a header until
    // its transaction completes, then idle for a random gap. A header marked
    // drain_first waits until every predicted result has come back.
    // -----------------------------------------------------------------------
    int send_gap = 0;

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_s_tvalid && !seg_taken)) begin
            if (send_gap > 0) begin
                i_s_tvalid <= 1'b0;
                send_gap--;
            end else if (segment_q.size() > 0 &&
                         !(segment_q[0].drain_first && awaited_results.size() > 0)) begin
                cur_seg = segment_q.pop_front();
                i_s_tdata  <= {cur_seg.random_seq, cur_seg.peer_seq, cur_seg.local_port,
                               cur_seg.peer_port, cur_seg.peer_ip};
                i_s_tuser  <= cur_seg.flags;
                i_s_tvalid <= 1'b1;
                sent_count++;
                // every fourth block of 100 headers goes back to back
                if ((sent_count / 100) % 4 == 1 || $urandom_range(9) < 6) begin
                    send_gap = 0;
                end else if ($urandom_range(19) == 0) begin
                    send_gap = $urandom_range(100, 20);
                end else begin
                    send_gap = $urandom_range(4, 1);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: change tready at the falling edge. Random stalls, a calm
    // stretch, and one long hold-off that lets the block fill up and stall
    // its slave side while the driver keeps offering headers.
    // -----------------------------------------------------------------------
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && results_seen >= 200) begin
            i_m_tready <= 1'b0;
            hold_left = 500;
            hold_done = 1'b1;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else if ((results_seen / 100) % 4 == 2 || $urandom_range(9) < 7) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= 1'b0;
            stall_left = ($urandom_range(19) == 0) ? $urandom_range(100, 20)
                                                   : $urandom_range(3, 0);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------
    initial begin
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [PORT_W-1:0] lport;
        logic [SEQ_W-1:0]  sq;
        int                directed;
        int                n;
        bit                mid_drain_done;

        mid_drain_done = 1'b0;
        for (int i = 0; i < 4; i++) begin
            ip_set[i]   = $urandom();
            port_set[i] = PORT_W'($urandom());
        end
        // twins that differ from the originals in a single bit
        for (int i = 4; i < 8; i++) begin
            ip_set[i]   = ip_set[i - 4] ^ (32'd1 << $urandom_range(31));
            port_set[i] = port_set[i - 4] ^ (16'd1 << $urandom_range(15));
        end

        // all-zero peer: must not match the cleared entries
        queue_segment('0, '0, '0, '0, FL_SYN, '0);
        // all-ones peer: acknowledgement number wraps to zero
        queue_segment('1, '1, '1, '1, FL_SYN, '1);
        // pure SYN again on a known peer: entry refreshed, new reply
        queue_segment('0, '0, 16'h1234, 32'h8000_0000, FL_SYN, 32'h1234_5678);
        // new peers that differ from known ones in one half of the key
        queue_segment('0, '1, PORT_W'($urandom()), pick_seq(), FL_ACK, $urandom());
        queue_segment('1, '0, PORT_W'($urandom()), pick_seq(), FL_NONE, $urandom());
        // every flag combination: even ones on a known peer, odd ones on new peers
        for (int f = 0; f < 16; f++) begin
            if (f % 2 == 0) begin
                queue_segment('0, '0, PORT_W'($urandom()), pick_seq(), S_TUSER_W'(f),
                              $urandom());
            end else begin
                queue_segment(32'hC0A8_0000 | f, PORT_W'(f), PORT_W'($urandom()), pick_seq(),
                              S_TUSER_W'(f), $urandom());
            end
        end
        directed = queued;

        // drain the directed part before the random traffic starts
        drain_next = 1'b1;
        while (queued < directed + RANDOM_ITEMS) begin
            if (!mid_drain_done && queued >= directed + RANDOM_ITEMS / 2) begin
                drain_next     = 1'b1;
                mid_drain_done = 1'b1;
            end
            pick_peer(ip, port);
            if ($urandom_range(99) < 70) begin
                // well-formed open, data and close on one connection
                lport = PORT_W'($urandom());
                sq    = pick_seq();
                queue_segment(ip, port, lport, sq, FL_SYN, $urandom());
                if ($urandom_range(7) == 0) begin
                    queue_segment(ip, port, lport, sq, FL_SYN, $urandom());
                end
                queue_segment(ip, port, lport, sq + 32'd1, FL_ACK, $urandom());
                n = $urandom_range(3);
                repeat (n) begin
                    queue_segment(ip, port, lport, $urandom(), FL_ACK | FL_PSH, $urandom());
                end
                queue_segment(ip, port, lport, $urandom(), FL_ACK | FL_FIN, $urandom());
            end else begin
                // stray header with arbitrary flags
                queue_segment(ip, port, PORT_W'($urandom()), pick_seq(),
                              S_TUSER_W'($urandom_range(15)), $urandom());
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (segment_q.size() != 0 || i_s_tvalid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        // let a stray late result show up before closing the run
        repeat (TBL + 10) @(posedge i_clk);

        $display("Run covered %0d headers (%0d directed), %0d results checked.",
                 accepted, directed, results_seen);
        $display("Entries claimed: %0d, SYN-ACK replies: %0d, full-table misses: %0d.",
                 created_seen, replies_seen, full_misses);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
